[rtl/core/tpsa_pkg.sv]
// Package for the two-pool slot allocator: request and result payload types,
// status and function codes, sequencer states. No dependencies.
package tpsa_pkg;

    localparam int HANDLE_W = 6;
    localparam int BYTES_W  = 16;
    localparam int OUT_W    = 5;

    localparam logic       FUNC_ALLOC = 1'b0;
    localparam logic       FUNC_FREE  = 1'b1;

    localparam logic       CFG_SMALL_BYTES = 1'b0;
    localparam logic       CFG_LARGE_BYTES = 1'b1;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_TOO_LARGE   = 3'd1;
    localparam logic [2:0] ST_NO_SLOT     = 3'd2;
    localparam logic [2:0] ST_DOUBLE_FREE = 3'd3;
    localparam logic [2:0] ST_UNKNOWN     = 3'd4;

    typedef struct packed {
        logic                func;
        logic [BYTES_W-1:0]  request_bytes;
        logic [HANDLE_W-1:0] slot_handle;
    } t_request;

    typedef struct packed {
        logic [2:0]       status;
        logic [OUT_W-1:0] granted_slot;
        logic [OUT_W-1:0] small_in_use;
        logic [OUT_W-1:0] large_in_use;
    } t_result;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SIZE_LG,
        S_SIZE_SM,
        S_SCAN_SM,
        S_SCAN_LG,
        S_FREE_DEC,
        S_FREE_SM,
        S_FREE_LG,
        S_DONE
    } t_state;

endpackage

[rtl/core/two_pool_slot_allocator.sv]
// Two-pool fixed-size slot allocator: sequencer, slot marks, in-use counts.
// Depends on tpsa_pkg.
//
//  channel   handshake          payload
//  --------  -----------------  -----------------------------------
//  request   start, busy        i_req   (func, request_bytes, slot_handle)
//  result    o_done (strobe)    o_result (status, granted_slot, counts)
//  config    i_cfg_we           i_cfg_idx, i_cfg_data
//
// Allocate: two size checks through one shared 16-bit comparator, a scan
// that tests the slot marks one at a time, then the result cycle; a size
// above the large limit goes straight to the result after the first check.
// Free: handle decode, slot mark test, result; a handle outside both pools skips the test.
// busy stays high from acceptance through the o_done cycle.
// Synchronous active-low reset frees all slots and restores the size limits.
// The receiver cannot stall; o_done marks each result for one cycle.
module two_pool_slot_allocator #(
    parameter int NUM_SMALL_SLOTS = 16,
    parameter int NUM_LARGE_SLOTS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  tpsa_pkg::t_request i_req,
    output logic               o_done,
    output tpsa_pkg::t_result  o_result,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [15:0]        i_cfg_data
);
    import tpsa_pkg::*;

    localparam int SIW = (NUM_SMALL_SLOTS > 1) ? $clog2(NUM_SMALL_SLOTS) : 1;
    localparam int LIW = (NUM_LARGE_SLOTS > 1) ? $clog2(NUM_LARGE_SLOTS) : 1;
    localparam int IW  = (SIW > LIW) ? SIW : LIW;
    localparam int SCW = $clog2(NUM_SMALL_SLOTS + 1);
    localparam int LCW = $clog2(NUM_LARGE_SLOTS + 1);

    t_state r_state, n_state;

    logic [BYTES_W-1:0]         r_small_bytes, r_large_bytes;
    logic [BYTES_W-1:0]         r_req_bytes, n_req_bytes;
    logic [HANDLE_W-1:0]        r_handle, n_handle;
    logic [IW-1:0]              r_idx, n_idx;
    logic [2:0]                 r_status, n_status;
    logic [HANDLE_W-1:0]        r_granted, n_granted;
    logic [NUM_SMALL_SLOTS-1:0] r_small_map, n_small_map;
    logic [NUM_LARGE_SLOTS-1:0] r_large_map, n_large_map;
    logic [SCW-1:0]             r_small_cnt, n_small_cnt;
    logic [LCW-1:0]             r_large_cnt, n_large_cnt;

    logic                accept;
    logic [BYTES_W-1:0]  cmp_b;
    logic                cmp_gt;
    logic [SIW-1:0]      idx_s;
    logic [LIW-1:0]      idx_l;
    logic                mark;
    logic                last_s, last_l;
    logic [HANDLE_W:0]   handle_x;
    logic [HANDLE_W:0]   handle_lg;
    logic                in_small, in_large;
    logic [HANDLE_W-1:0] grant_s, grant_l;
    logic [HANDLE_W:0]   small_cnt_x, large_cnt_x;

    assign accept = start && !busy;

    // shared comparator: request size against the limit of the current check
    assign cmp_b  = (r_state == S_SIZE_LG) ? r_large_bytes : r_small_bytes;
    assign cmp_gt = r_req_bytes > cmp_b;

    assign idx_s  = r_idx[SIW-1:0];
    assign idx_l  = r_idx[LIW-1:0];
    assign last_s = r_idx == IW'(NUM_SMALL_SLOTS - 1);
    assign last_l = r_idx == IW'(NUM_LARGE_SLOTS - 1);
    assign mark   = (r_state == S_SCAN_SM || r_state == S_FREE_SM) ?
                    r_small_map[idx_s] : r_large_map[idx_l];

    assign handle_x  = {1'b0, r_handle};
    assign handle_lg = handle_x - (HANDLE_W+1)'(NUM_SMALL_SLOTS);
    assign in_small  = handle_x < (HANDLE_W+1)'(NUM_SMALL_SLOTS);
    assign in_large  = handle_x < (HANDLE_W+1)'(NUM_SMALL_SLOTS + NUM_LARGE_SLOTS);

    assign grant_s = HANDLE_W'(idx_s);
    assign grant_l = HANDLE_W'(NUM_SMALL_SLOTS) + HANDLE_W'(idx_l);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (i_req.func == FUNC_FREE) ? S_FREE_DEC : S_SIZE_LG;
                end
            end
            S_SIZE_LG:  n_state = cmp_gt ? S_DONE : S_SIZE_SM;
            S_SIZE_SM:  n_state = cmp_gt ? S_SCAN_LG : S_SCAN_SM;
            S_SCAN_SM: begin
                if (!mark) begin
                    n_state = S_DONE;
                end else if (last_s) begin
                    n_state = S_SCAN_LG;
                end
            end
            S_SCAN_LG: begin
                if (!mark || last_l) begin
                    n_state = S_DONE;
                end
            end
            S_FREE_DEC: begin
                if (in_small) begin
                    n_state = S_FREE_SM;
                end else if (in_large) begin
                    n_state = S_FREE_LG;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_FREE_SM:  n_state = S_DONE;
            S_FREE_LG:  n_state = S_DONE;
            S_DONE:     n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // datapath updates
    always_comb begin
        n_req_bytes = r_req_bytes;
        n_handle    = r_handle;
        n_idx       = r_idx;
        n_status    = r_status;
        n_granted   = r_granted;
        n_small_map = r_small_map;
        n_large_map = r_large_map;
        n_small_cnt = r_small_cnt;
        n_large_cnt = r_large_cnt;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_req_bytes = i_req.request_bytes;
                    n_handle    = i_req.slot_handle;
                    n_status    = ST_OK;
                    n_granted   = '0;
                end
            end
            S_SIZE_LG: begin
                if (cmp_gt) begin
                    n_status = ST_TOO_LARGE;
                end
            end
            S_SIZE_SM: begin
                n_idx = '0;
            end
            S_SCAN_SM: begin
                if (!mark) begin
                    n_small_map[idx_s] = 1'b1;
                    n_small_cnt        = r_small_cnt + SCW'(1);
                    n_granted          = grant_s;
                end else if (last_s) begin
                    n_idx = '0;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            S_SCAN_LG: begin
                if (!mark) begin
                    n_large_map[idx_l] = 1'b1;
                    n_large_cnt        = r_large_cnt + LCW'(1);
                    n_granted          = grant_l;
                end else if (last_l) begin
                    n_status = ST_NO_SLOT;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            S_FREE_DEC: begin
                if (in_small) begin
                    n_idx = IW'(r_handle);
                end else if (in_large) begin
                    n_idx = IW'(handle_lg);
                end else begin
                    n_status = ST_UNKNOWN;
                end
            end
            S_FREE_SM: begin
                if (!mark) begin
                    n_status = ST_DOUBLE_FREE;
                end else begin
                    n_small_map[idx_s] = 1'b0;
                    n_small_cnt        = r_small_cnt - SCW'(1);
                end
            end
            S_FREE_LG: begin
                if (!mark) begin
                    n_status = ST_DOUBLE_FREE;
                end else begin
                    n_large_map[idx_l] = 1'b0;
                    n_large_cnt        = r_large_cnt - LCW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_small_bytes <= 16'd64;
            r_large_bytes <= 16'd1024;
            r_small_map   <= '0;
            r_large_map   <= '0;
            r_small_cnt   <= '0;
            r_large_cnt   <= '0;
        end else begin
            r_state     <= n_state;
            r_small_map <= n_small_map;
            r_large_map <= n_large_map;
            r_small_cnt <= n_small_cnt;
            r_large_cnt <= n_large_cnt;
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_SMALL_BYTES) begin
                    r_small_bytes <= i_cfg_data;
                end else begin
                    r_large_bytes <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req_bytes <= n_req_bytes;
        r_handle    <= n_handle;
        r_idx       <= n_idx;
        r_status    <= n_status;
        r_granted   <= n_granted;
    end

    // outputs
    assign small_cnt_x = (HANDLE_W+1)'(r_small_cnt);
    assign large_cnt_x = (HANDLE_W+1)'(r_large_cnt);

    always_comb begin
        busy                  = r_state != S_IDLE;
        o_done                = r_state == S_DONE;
        o_result.status       = r_status;
        o_result.granted_slot = r_granted[OUT_W-1:0];
        o_result.small_in_use = small_cnt_x[OUT_W-1:0];
        o_result.large_in_use = large_cnt_x[OUT_W-1:0];
    end

    a_done_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy)
        else $error("busy held after result strobe");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy && !o_done)
        else $error("accepted request did not raise busy");

    a_small_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_small_cnt) == 32'($countones(r_small_map)))
        else $error("small in-use count disagrees with slot marks");

    a_large_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_large_cnt) == 32'($countones(r_large_map)))
        else $error("large in-use count disagrees with slot marks");

    a_err_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status != ST_OK) |-> o_result.granted_slot == '0)
        else $error("granted slot reported on an error");

endmodule

[sim/tb_two_pool_slot_allocator.sv]
`timescale 1ns / 100ps
// Self-checking testbench for two_pool_slot_allocator: queued alloc/free requests,
// an in-bench slot-map predictor and a result checker. Depends on tpsa_pkg and the RTL.
module tb_two_pool_slot_allocator;
    import tpsa_pkg::*;

    localparam int SMALL_SLOTS = 16;
    localparam int LARGE_SLOTS = 16;

    logic        i_clk;
    logic        i_rst_n    = 1'b0;
    logic        start      = 1'b0;
    logic        busy;
    t_request    i_req      = '0;
    logic        o_done;
    t_result     o_result;
    logic        i_cfg_we   = 1'b0;
    logic        i_cfg_idx  = CFG_SMALL_BYTES;
    logic [15:0] i_cfg_data = '0;

    two_pool_slot_allocator #(
        .NUM_SMALL_SLOTS(SMALL_SLOTS),
        .NUM_LARGE_SLOTS(LARGE_SLOTS)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_req     (i_req),
        .o_done    (o_done),
        .o_result  (o_result),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    t_request pending_requests[$];
    t_result  due_results[$];
    int       errors   = 0;
    int       gap_pct  = 0;
    logic     req_taken = 1'b0;

    // predictor state
    logic [SMALL_SLOTS-1:0] small_map;
    logic [LARGE_SLOTS-1:0] large_map;
    logic [4:0]             small_count;
    logic [4:0]             large_count;
    logic [15:0]            small_limit;
    logic [15:0]            large_limit;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_error(string msg);
        errors++;
        $display("%0t ns: %s", $time, msg);
    endtask

    // Apply one request to the slot maps and return the result it produces.
    function automatic t_result slot_outcome(t_request r);
        t_result res;
        int      slot;
        res = '0;
        res.status = ST_OK;
        slot = -1;
        if (r.func == FUNC_ALLOC) begin
            if (r.request_bytes > large_limit) begin
                res.status = ST_TOO_LARGE;
            end else begin
                if (r.request_bytes <= small_limit) begin
                    for (int i = SMALL_SLOTS - 1; i >= 0; i--)
                        if (!small_map[i]) slot = i;
                    if (slot >= 0) begin
                        small_map[slot] = 1'b1;
                        small_count++;
                        res.granted_slot = 5'(slot);
                    end
                end
                if (slot < 0) begin
                    for (int i = LARGE_SLOTS - 1; i >= 0; i--)
                        if (!large_map[i]) slot = i;
                    if (slot >= 0) begin
                        large_map[slot] = 1'b1;
                        large_count++;
                        res.granted_slot = 5'(SMALL_SLOTS + slot);
                    end else begin
                        res.status = ST_NO_SLOT;
                    end
                end
            end
        end else if (r.slot_handle < SMALL_SLOTS) begin
            if (!small_map[r.slot_handle]) begin
                res.status = ST_DOUBLE_FREE;
            end else begin
                small_map[r.slot_handle] = 1'b0;
                small_count--;
            end
        end else if (r.slot_handle < SMALL_SLOTS + LARGE_SLOTS) begin
            if (!large_map[r.slot_handle - SMALL_SLOTS]) begin
                res.status = ST_DOUBLE_FREE;
            end else begin
                large_map[r.slot_handle - SMALL_SLOTS] = 1'b0;
                large_count--;
            end
        end else begin
            res.status = ST_UNKNOWN;
        end
        res.small_in_use = small_count;
        res.large_in_use = large_count;
        return res;
    endfunction

    // Driver: hold a request until it is taken, otherwise maybe idle.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !req_taken) begin
            start <= 1'b1;
        end else if (pending_requests.size() > 0 && $urandom_range(99) >= gap_pct) begin
            start <= 1'b1;
            i_req <= pending_requests.pop_front();
        end else begin
            start <= 1'b0;
        end
    end

    // Monitor: predict on acceptance, check on each done strobe.
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            small_map   = '0;
            large_map   = '0;
            small_count = '0;
            large_count = '0;
            small_limit = 16'd64;
            large_limit = 16'd1024;
            due_results.delete();
            req_taken <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_SMALL_BYTES)
                    small_limit = i_cfg_data;
                else
                    large_limit = i_cfg_data;
            end
            if (o_done) begin
                if (due_results.size() == 0) begin
                    report_error($sformatf("result with no request outstanding: %h", o_result));
                end else begin
                    want = due_results.pop_front();
                    if (o_result.status !== want.status)
                        report_error($sformatf("status got %0d expected %0d",
                                               o_result.status, want.status));
                    if (o_result.granted_slot !== want.granted_slot)
                        report_error($sformatf("granted_slot got %0d expected %0d",
                                               o_result.granted_slot, want.granted_slot));
                    if (o_result.small_in_use !== want.small_in_use)
                        report_error($sformatf("small_in_use got %0d expected %0d",
                                               o_result.small_in_use, want.small_in_use));
                    if (o_result.large_in_use !== want.large_in_use)
                        report_error($sformatf("large_in_use got %0d expected %0d",
                                               o_result.large_in_use, want.large_in_use));
                end
            end
            if (start && !busy)
                due_results.push_back(slot_outcome(i_req));
            req_taken <= start && !busy;
        end
    end

    function automatic t_request make_request(logic func, logic [15:0] bytes,
                                              logic [5:0] handle);
        t_request r;
        r.func          = func;
        r.request_bytes = bytes;
        r.slot_handle   = handle;
        return r;
    endfunction

    // Sizes clustered around the two limits, plus fully random ones.
    function automatic logic [15:0] pick_bytes(logic [15:0] sm, logic [15:0] lg);
        case ($urandom_range(7))
            0:       return 16'd0;
            1:       return sm;
            2:       return sm + 16'd1;
            3:       return lg;
            4:       return lg + 16'd1;
            5:       return 16'($urandom_range(sm));
            6:       return 16'($urandom_range(lg));
            default: return 16'($urandom);
        endcase
    endfunction

    // Alternate alloc-heavy and free-heavy stretches so pools fill and drain.
    task automatic queue_random(int n, logic [15:0] sm, logic [15:0] lg);
        int         alloc_pct;
        logic [5:0] handle;
        for (int k = 0; k < n; k++) begin
            alloc_pct = ((k / 40) % 2 == 0) ? 80 : 30;
            if ($urandom_range(99) < 8)
                handle = 6'($urandom_range(63, SMALL_SLOTS + LARGE_SLOTS));
            else
                handle = 6'($urandom_range(SMALL_SLOTS + LARGE_SLOTS - 1));
            if ($urandom_range(99) < alloc_pct)
                pending_requests.push_back(make_request(FUNC_ALLOC, pick_bytes(sm, lg),
                                                        6'($urandom)));
            else
                pending_requests.push_back(make_request(FUNC_FREE, 16'($urandom), handle));
        end
    endtask

    task automatic drain();
        while (pending_requests.size() > 0 || start || busy || due_results.size() > 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_limit(logic idx, logic [15:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    initial begin
        logic [15:0] sm;
        logic [15:0] lg;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // defaults: 64 / 1024
        gap_pct = 17;
        pending_requests.push_back(make_request(FUNC_ALLOC, 16'd0,     6'h3F));
        pending_requests.push_back(make_request(FUNC_ALLOC, 16'd64,    6'd0));
        pending_requests.push_back(make_request(FUNC_ALLOC, 16'd65,    6'd0));
        pending_requests.push_back(make_request(FUNC_ALLOC, 16'd1024,  6'd0));
        pending_requests.push_back(make_request(FUNC_ALLOC, 16'd1025,  6'd0));
        pending_requests.push_back(make_request(FUNC_ALLOC, 16'hFFFF,  6'h3F));
        pending_requests.push_back(make_request(FUNC_FREE,  16'hFFFF,  6'd0));
        pending_requests.push_back(make_request(FUNC_FREE,  16'd0,     6'd0));
        pending_requests.push_back(make_request(FUNC_FREE,  16'd0,     6'd17));
        pending_requests.push_back(make_request(FUNC_FREE,  16'd0,     6'd17));
        pending_requests.push_back(make_request(FUNC_FREE,  16'd0,     6'd31));
        pending_requests.push_back(make_request(FUNC_FREE,  16'd0,     6'd15));
        pending_requests.push_back(make_request(FUNC_FREE,  16'd0,     6'd32));
        pending_requests.push_back(make_request(FUNC_FREE,  16'd0,     6'd63));
        pending_requests.push_back(make_request(FUNC_FREE,  16'd0,     6'd1));
        pending_requests.push_back(make_request(FUNC_FREE,  16'd0,     6'd16));
        queue_random(235, 16'd64, 16'd1024);
        drain();

        // small limit of 1, largest large limit
        gap_pct = 67;
        write_limit(CFG_SMALL_BYTES, 16'd1);
        write_limit(CFG_LARGE_BYTES, 16'hFFFF);
        queue_random(235, 16'd1, 16'hFFFF);
        drain();

        // small limit above large limit: the too-large check must win
        gap_pct = 0;
        write_limit(CFG_SMALL_BYTES, 16'hFFFF);
        write_limit(CFG_LARGE_BYTES, 16'd1);
        pending_requests.push_back(make_request(FUNC_ALLOC, 16'd2, 6'd0));
        queue_random(235, 16'hFFFF, 16'd1);
        drain();

        sm = 16'($urandom_range(1, 2000));
        lg = 16'($urandom_range(1, 8000));
        write_limit(CFG_SMALL_BYTES, sm);
        write_limit(CFG_LARGE_BYTES, lg);
        queue_random(235, sm, lg);
        drain();

        repeat (40) @(posedge i_clk);
        if (errors == 0)
            $display("tb_two_pool_slot_allocator: clean");
        else
            $display("tb_two_pool_slot_allocator: errors");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout waiting for results");
        $display("tb_two_pool_slot_allocator: errors");
        $finish;
    end

endmodule
